>>> rtl/vn2c_pkg.sv
`default_nettype none
package vn2c_pkg;

    // lattice and coordinate defaults
    localparam int COORD_BITS_DEF   = 24;
    localparam int COS_TABLE_ENTRIES = 2048;
    localparam int COS_HALF          = COS_TABLE_ENTRIES / 2;
    localparam int COS_QUARTER       = COS_HALF / 2;
    localparam int IDX_BITS          = $clog2(COS_HALF);
    localparam int FLOG_BITS         = 4;
    localparam int VAL_BITS          = 9;
    localparam int WGT_BITS          = 16;

    // angle step of one table entry
    localparam real COS_STEP = 2.0 * 3.14159265358979323846 / real'(COS_TABLE_ENTRIES);

    // the hash output only uses bits 26..19, so all hash arithmetic is mod 2^27
    localparam int HASH_BITS = 27;
    localparam int LANES     = 16;

    localparam logic [HASH_BITS-1:0] ROW_STRIDE = HASH_BITS'(57);
    localparam logic [HASH_BITS-1:0] HASH_K1    = HASH_BITS'(15731);
    localparam logic [HASH_BITS-1:0] HASH_K2    = HASH_BITS'(789221);
    localparam logic [HASH_BITS-1:0] HASH_K3    = HASH_BITS'(32'd1376312589);
    localparam int                   HASH_SHIFT = 13;
    localparam int                   HASH_POS   = 19;

    localparam logic [16:0] WGT_ONE = 17'd65536;

    typedef logic [WGT_BITS-1:0] t_wtab [COS_HALF];
    typedef logic [7:0]          t_hash_vec [LANES];

    // interpolation weight (65536 - trunc(65536*cos)) / 2 for one table entry
    function automatic logic [WGT_BITS-1:0] cos_weight(input int k);
        real c;
        int  r;
        c = $cos(COS_STEP * real'(k));
        r = $rtoi(65536.0 * c);
        if (k == 0) begin
            r = 65536;
        end
        if (k == COS_QUARTER) begin
            r = 0;
        end
        return WGT_BITS'((65536 - r) >>> 1);
    endfunction

    function automatic t_wtab build_wtab();
        t_wtab t;
        for (int k = 0; k < COS_HALF; k++) begin
            t[k] = cos_weight(k);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

>>> rtl/vn2c_hash.sv
`default_nettype none
// sixteen lattice hash lanes, four register stages
module vn2c_hash (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [vn2c_pkg::HASH_BITS-1:0] i_base,
    output vn2c_pkg::t_hash_vec                o_hash
);
    localparam int HB = vn2c_pkg::HASH_BITS;
    localparam int NL = vn2c_pkg::LANES;

    logic [HB-1:0] r_n1 [NL];
    logic [HB-1:0] r_n2 [NL];
    logic [HB-1:0] r_p  [NL];
    logic [HB-1:0] r_m  [NL];
    logic [HB-1:0] r_t  [NL];
    logic [7:0]    r_h  [NL];

    for (genvar k = 0; k < NL; k++) begin : g_lane
        localparam int DX = (k % 4) - 1;
        localparam int DY = (k / 4) - 1;
        localparam logic [HB-1:0] OFS = HB'(DY * 57 + DX);

        logic [HB-1:0] n_n;
        logic [HB-1:0] n_u;

        // lattice index of this neighbour and bit mixing
        always_comb begin
            n_n = i_base + OFS;
            n_n = n_n ^ (n_n << vn2c_pkg::HASH_SHIFT);
        end

        assign n_u = r_p[k] + vn2c_pkg::HASH_K3;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n1[k] <= n_n;
                r_m[k]  <= HB'(n_n * n_n);
                r_n2[k] <= r_n1[k];
                r_t[k]  <= HB'(r_m[k] * vn2c_pkg::HASH_K1) + vn2c_pkg::HASH_K2;
                r_p[k]  <= HB'(r_n2[k] * r_t[k]);
                r_h[k]  <= n_u[vn2c_pkg::HASH_POS +: 8];
            end
        end

        assign o_hash[k] = r_h[k];
    end

endmodule
`default_nettype wire

>>> rtl/vn2c_blend.sv
`default_nettype none
// one cosine blend between two values, registered
module vn2c_blend (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [vn2c_pkg::VAL_BITS-1:0] i_a,
    input  wire logic [vn2c_pkg::VAL_BITS-1:0] i_b,
    input  wire logic [vn2c_pkg::WGT_BITS-1:0] i_w,
    output logic      [vn2c_pkg::VAL_BITS-1:0] o_value
);
    localparam int VB = vn2c_pkg::VAL_BITS;
    localparam int WB = vn2c_pkg::WGT_BITS;

    logic [VB+WB-1:0] n_pb;
    logic [VB+WB:0]   n_pa;
    logic [16:0]      n_wc;
    logic [VB:0]      n_sum;
    logic [VB-1:0]    r_value;

    // weighted sum of both ends
    always_comb begin
        n_wc  = vn2c_pkg::WGT_ONE - {1'b0, i_w};
        n_pb  = i_w * i_b;
        n_pa  = n_wc * i_a;
        n_sum = (VB+1)'(n_pb >> WB) + (VB+1)'(n_pa >> WB);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_sum[VB-1:0];
        end
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

>>> rtl/value_noise_2d_cosine.sv
`default_nettype none
// Two-dimensional value noise with cosine interpolation. One coordinate pair is
// taken every cycle unless the output stalls; a stall on the output holds the
// whole pipeline, so throughput is one sample per cycle while the output is
// taken. The stages are: cell split and row base, cosine weight lookup and first
// hash mixing, three stages of hash multiplies over sixteen lattice lanes, corner
// smoothing, the two x blends, and the y blend.
// Coordinates are unsigned; neighbours outside the range wrap before hashing.
module value_noise_2d_cosine #(
    parameter int COORD_BITS = vn2c_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [COORD_BITS-1:0]          i_coord_x,
    input  wire logic [COORD_BITS-1:0]          i_coord_y,
    input  wire logic [vn2c_pkg::FLOG_BITS-1:0] i_freq_log2,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [vn2c_pkg::VAL_BITS-1:0]  o_noise_value
);
    localparam int CB    = COORD_BITS;
    localparam int HB    = vn2c_pkg::HASH_BITS;
    localparam int IB    = vn2c_pkg::IDX_BITS;
    localparam int WB    = vn2c_pkg::WGT_BITS;
    localparam int VB    = vn2c_pkg::VAL_BITS;
    localparam int DEPTH = 8;
    localparam vn2c_pkg::t_wtab W_TAB = vn2c_pkg::build_wtab();

    logic             w_en;
    logic [DEPTH-1:0] r_valid;

    // stage 1 signals
    logic [CB-1:0]    n_fmask;
    logic [CB-1:0]    n_px, n_py, n_fx, n_fy;
    logic [CB+IB-1:0] n_sx, n_sy;
    logic [HB-1:0]    r_base;
    logic [IB-1:0]    r_idx_x, r_idx_y;

    // weight delay lines
    logic [WB-1:0]    r_wx [2:6];
    logic [WB-1:0]    r_wy [2:7];

    vn2c_pkg::t_hash_vec w_hash;
    logic [VB-1:0]    r_sv [4];
    logic [VB-1:0]    w_i1, w_i2;

    assign w_en    = !r_valid[DEPTH-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid[DEPTH-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    // cell split, fraction to table index, row base
    always_comb begin
        n_fmask = ~({CB{1'b1}} << i_freq_log2);
        n_px    = i_coord_x >> i_freq_log2;
        n_py    = i_coord_y >> i_freq_log2;
        n_fx    = i_coord_x & n_fmask;
        n_fy    = i_coord_y & n_fmask;
        n_sx    = {n_fx, {IB{1'b0}}} >> i_freq_log2;
        n_sy    = {n_fy, {IB{1'b0}}} >> i_freq_log2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_base  <= HB'(HB'(n_py) * vn2c_pkg::ROW_STRIDE) + HB'(n_px);
            r_idx_x <= n_sx[IB-1:0];
            r_idx_y <= n_sy[IB-1:0];
        end
    end

    // cosine weight lookup, then delay to the blend stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wx[2] <= W_TAB[r_idx_x];
            r_wy[2] <= W_TAB[r_idx_y];
            for (int s = 3; s <= 6; s++) begin
                r_wx[s] <= r_wx[s-1];
            end
            for (int s = 3; s <= 7; s++) begin
                r_wy[s] <= r_wy[s-1];
            end
        end
    end

    vn2c_hash u_hash (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_base (r_base),
        .o_hash (w_hash)
    );

    // smoothing over each corner's neighbourhood
    function automatic logic [VB-1:0] smooth(input vn2c_pkg::t_hash_vec h,
                                             input int gx, input int gy);
        logic [9:0] c, s;
        logic [7:0] m;
        c = 10'(h[(gy-1)*4+gx-1]) + 10'(h[(gy-1)*4+gx+1])
          + 10'(h[(gy+1)*4+gx-1]) + 10'(h[(gy+1)*4+gx+1]);
        s = 10'(h[gy*4+gx-1]) + 10'(h[gy*4+gx+1])
          + 10'(h[(gy-1)*4+gx]) + 10'(h[(gy+1)*4+gx]);
        m = h[gy*4+gx];
        return VB'(c >> 4) + VB'(s >> 2) + VB'(m >> 4);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sv[0] <= smooth(w_hash, 1, 1);
            r_sv[1] <= smooth(w_hash, 2, 1);
            r_sv[2] <= smooth(w_hash, 1, 2);
            r_sv[3] <= smooth(w_hash, 2, 2);
        end
    end

    // blends along x, then along y
    vn2c_blend u_blend_top (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (r_sv[0]),
        .i_b     (r_sv[1]),
        .i_w     (r_wx[6]),
        .o_value (w_i1)
    );

    vn2c_blend u_blend_bot (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (r_sv[2]),
        .i_b     (r_sv[3]),
        .i_w     (r_wx[6]),
        .o_value (w_i2)
    );

    vn2c_blend u_blend_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (w_i1),
        .i_b     (w_i2),
        .i_w     (r_wy[7]),
        .o_value (o_noise_value)
    );

    // checks
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_noise_value <= VB'(333))
        else $error("noise value above smoothed maximum");

    a_smooth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[5] |-> (r_sv[0] <= VB'(333) && r_sv[3] <= VB'(333)))
        else $error("smoothed corner out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_valid))
        else $error("pipeline moved during stall");

    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_valid == '0)
        else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire
